### hdl/bdd_pkg.sv
// Package for the bounded deque with delete: field widths, action and status
// codes, the cell load selector and the request and result structs.
// No dependencies.
package bdd_pkg;

  localparam int DataW        = 32;
  localparam int ActionW      = 3;
  localparam int StatusW      = 2;
  localparam int FillW        = 5;
  localparam int DefaultDepth = 16;

  // Request actions.
  localparam logic [ActionW-1:0] ActPushFront = 3'd0;
  localparam logic [ActionW-1:0] ActPushBack  = 3'd1;
  localparam logic [ActionW-1:0] ActPopFront  = 3'd2;
  localparam logic [ActionW-1:0] ActPopBack   = 3'd3;
  localparam logic [ActionW-1:0] ActDelete    = 3'd4;
  localparam logic [ActionW-1:0] ActDump      = 3'd5;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StEmpty    = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;
  localparam logic [StatusW-1:0] StFull     = 2'd3;

  // What a cell loads at the next clock edge.
  typedef enum logic [2:0] {
    SelHold,
    SelLeft,
    SelRight,
    SelValue,
    SelFront
  } sel_e;

  typedef struct packed {
    logic [ActionW-1:0]      action;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] data;
    logic                    last;
    logic [FillW-1:0]        fill;
  } res_t;

endpackage

### hdl/bdd_cell.sv
// One storage cell of the deque chain: holds one entry and takes its next
// value from a neighbor, the request value or the front cell.
// Depends on bdd_pkg.
module bdd_cell (
  input  logic                             clk_i,
  input  bdd_pkg::sel_e                    sel_i,
  input  logic                             in_use_i,
  input  logic signed [bdd_pkg::DataW-1:0] left_i,
  input  logic signed [bdd_pkg::DataW-1:0] right_i,
  input  logic signed [bdd_pkg::DataW-1:0] front_i,
  input  logic signed [bdd_pkg::DataW-1:0] value_i,
  input  logic                             hit_before_i,
  output logic                             hit_o,
  output logic signed [bdd_pkg::DataW-1:0] data_o
);
  import bdd_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;

  // The hit flag ripples down the chain, so it is high from the first held
  // match onward.
  assign hit_o  = hit_before_i | (in_use_i & (data_q == value_i));
  assign data_o = data_q;

  always_comb begin
    unique case (sel_i)
      SelLeft:  data_d = left_i;
      SelRight: data_d = right_i;
      SelValue: data_d = value_i;
      SelFront: data_d = front_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

### hdl/bounded_deque_with_delete.sv
// Top level of the bounded deque with delete: the occupancy counter, the
// request decoder, the dump sequencer and the output register over a chain
// of bdd_cell instances. Depends on bdd_pkg and bdd_cell.

// The block keeps an ordered list of up to DEPTH signed 32-bit values in a
// row of cells, front in cell 0. Push front shifts every cell one place
// toward the back, push back writes the cell just past the fill, pop front
// shifts every cell toward the front, and pop back only lowers the count.
// A delete compares the value in every held cell at once; a hit flag
// ripples down the chain and every cell at or behind the first match takes
// its right neighbor, which closes the gap and keeps the order of the rest.
// Each of these requests gives one result. A dump of N held entries is
// accepted and then sends one entry per step, each step waiting until the
// output register is free: in each step the front cell goes to the output
// register and the held part of the chain rotates by one place, so after N
// steps the list stands as before. New requests are held off during a dump.
// A dump of an empty list gives one result with the empty status. A push to
// a full list is refused with the full status, a pop or delete on an empty
// list gives the empty status and a delete of an absent value gives the not
// found status. Unknown actions change nothing and give an ok result. Every
// result carries the fill after its request, taken modulo 32; data is the
// listed entry during a dump and zero otherwise. The result sits in an
// output register, so a stalled result holds while the block stays ready as
// soon as that register is free.
module bounded_deque_with_delete #(
  parameter int DEPTH = bdd_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bdd_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bdd_pkg::res_t out_res_o
);
  import bdd_pkg::*;

  localparam int OccW = $clog2(DEPTH + 1);
  localparam logic [OccW-1:0] OccFull = OccW'(DEPTH);
  localparam logic [OccW-1:0] OccOne  = OccW'(1);

  // Control state.
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] rem_q, rem_d;
  logic            dump_q, dump_d;
  logic            out_valid_q, out_valid_d;

  // Result payload.
  res_t res_q, res_d;

  // Chain wiring.
  sel_e                    sel[DEPTH];
  logic                    in_use[DEPTH];
  logic signed [DataW-1:0] cell_data[DEPTH];
  logic                    hit[DEPTH+1];

  logic take;
  logic out_free;
  logic is_full;
  logic is_empty;
  logic found;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = dump_q || !out_free;
  assign take       = in_valid_i && !in_stall_o;
  assign is_full    = (occ_q == OccFull);
  assign is_empty   = (occ_q == '0);
  assign found      = hit[DEPTH];
  assign hit[0]     = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] left_w;
    logic signed [DataW-1:0] right_w;

    assign in_use[g] = (OccW'(g) < occ_q);

    // The front cell never loads from its left, so that end is tied to a harmless
    // source; the back cell's right input is its own value, so loading it holds.
    if (g == 0) begin : g_front
      assign left_w = in_req_i.value;
    end else begin : g_inner_left
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_back
      assign right_w = cell_data[g];
    end else begin : g_inner_right
      assign right_w = cell_data[g+1];
    end

    bdd_cell u_cell (
      .clk_i        (clk_i),
      .sel_i        (sel[g]),
      .in_use_i     (in_use[g]),
      .left_i       (left_w),
      .right_i      (right_w),
      .front_i      (cell_data[0]),
      .value_i      (in_req_i.value),
      .hit_before_i (hit[g]),
      .hit_o        (hit[g+1]),
      .data_o       (cell_data[g])
    );
  end

  always_comb begin
    occ_d       = occ_q;
    rem_d       = rem_q;
    dump_d      = dump_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = SelHold;
    end

    if (dump_q && out_free) begin
      // One dump step: send the front entry and rotate the held part.
      res_d.status = StOk;
      res_d.data   = cell_data[0];
      res_d.last   = (rem_q == OccOne);
      res_d.fill   = FillW'(occ_q);
      out_valid_d  = 1'b1;
      rem_d        = rem_q - OccOne;
      dump_d       = (rem_q != OccOne);
      for (int i = 0; i < DEPTH; i++) begin
        if (OccW'(i) + OccOne == occ_q) begin
          sel[i] = SelFront;
        end else if (OccW'(i) + OccOne < occ_q) begin
          sel[i] = SelRight;
        end
      end
    end else if (take) begin
      res_d.status = StOk;
      res_d.data   = '0;
      res_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      unique case (in_req_i.action)
        ActPushFront: begin
          if (is_full) begin
            res_d.status = StFull;
          end else begin
            occ_d = occ_q + OccOne;
            for (int i = 0; i < DEPTH; i++) begin
              sel[i] = (i == 0) ? SelValue : SelLeft;
            end
          end
        end
        ActPushBack: begin
          if (is_full) begin
            res_d.status = StFull;
          end else begin
            occ_d = occ_q + OccOne;
            for (int i = 0; i < DEPTH; i++) begin
              if (OccW'(i) == occ_q) begin
                sel[i] = SelValue;
              end
            end
          end
        end
        ActPopFront: begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else begin
            occ_d = occ_q - OccOne;
            for (int i = 0; i < DEPTH; i++) begin
              sel[i] = SelRight;
            end
          end
        end
        ActPopBack: begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else begin
            occ_d = occ_q - OccOne;
          end
        end
        ActDelete: begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else if (!found) begin
            res_d.status = StNotFound;
          end else begin
            occ_d = occ_q - OccOne;
            for (int i = 0; i < DEPTH; i++) begin
              if (hit[i+1]) begin
                sel[i] = SelRight;
              end
            end
          end
        end
        ActDump: begin
          if (is_empty) begin
            res_d.status = StEmpty;
          end else begin
            // The entries follow from the dump sequencer.
            out_valid_d = 1'b0;
            dump_d      = 1'b1;
            rem_d       = occ_q;
          end
        end
        default: begin
          // Unknown actions leave the list alone and report ok.
        end
      endcase
      res_d.fill = FillW'(occ_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rem_q       <= '0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      dump_q      <= dump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

### sim/bounded_deque_with_delete_tb.sv
// Self-checking testbench for the bounded deque with delete: a directed table,
// a long receiver hold-off that fills the list, then weighted random requests.
// Depends on bdd_pkg and the bounded_deque_with_delete RTL.
module bounded_deque_with_delete_tb;
  import bdd_pkg::*;

  localparam int Depth       = DefaultDepth;
  localparam int HoldCycles  = 120;
  localparam int DrainCycles = 40;
  localparam int RandBlocks  = 6;
  localparam int BlockItems  = 23;
  localparam int BurstPushes = Depth + 2;

  // The block treats the two unused action codes as no-ops.
  localparam logic [ActionW-1:0] ActUnused6 = 3'd6;
  localparam logic [ActionW-1:0] ActUnused7 = 3'd7;

  // One row of the directed table. Rows with typed set carry their expected
  // status and fill; the rest are checked against the predicted list.
  typedef struct {
    req_t             req;
    bit               typed;
    logic [StatusW-1:0] status;
    logic [FillW-1:0]   fill;
  } dir_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_stall_o;
  logic out_valid_o;
  res_t out_res_o;

  // Expectation that travels with a typed request, held stable with it.
  bit                 drv_typed  = 1'b0;
  logic [StatusW-1:0] drv_status = '0;
  logic [FillW-1:0]   drv_fill   = '0;

  // Predicted list contents, front at index 0.
  logic signed [DataW-1:0] held [Depth];
  int                      held_cnt = 0;

  res_t     step_results[$];
  res_t     expected_results[$];
  dir_row_t directed_rows[$];

  int errors       = 0;
  bit calm         = 1'b0;
  bit hold_pending = 1'b0;

  bounded_deque_with_delete #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("bounded_deque_with_delete_tb: done, errors");
    $finish;
  end

  // A result stamped with the list fill as it stands after the request.
  function automatic res_t mk_result(input logic [StatusW-1:0] st,
                                     input logic signed [DataW-1:0] d,
                                     input bit lst);
    res_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    r.fill   = held_cnt[FillW-1:0];
    return r;
  endfunction

  // Applies one request to the predicted list and leaves the results it
  // causes in step_results, in the order the block should emit them.
  function automatic void predict_request(input req_t r);
    logic [StatusW-1:0] st;
    int                 hit;
    int                 i;
    bit                 on_empty;
    step_results.delete();
    st  = StOk;
    hit = -1;
    on_empty = (held_cnt == 0) &&
               (r.action == ActPopFront || r.action == ActPopBack ||
                r.action == ActDelete || r.action == ActDump);
    if (on_empty) begin
      st = StEmpty;
    end else begin
      case (r.action)
        ActPushFront: begin
          if (held_cnt >= Depth) begin
            st = StFull;
          end else begin
            for (i = held_cnt; i > 0; i--) held[i] = held[i-1];
            held[0] = r.value;
            held_cnt++;
          end
        end
        ActPushBack: begin
          if (held_cnt >= Depth) begin
            st = StFull;
          end else begin
            held[held_cnt] = r.value;
            held_cnt++;
          end
        end
        ActPopFront: hit = 0;
        ActPopBack:  held_cnt--;
        ActDelete: begin
          // Only the first match from the front goes away.
          for (i = 0; i < held_cnt; i++) begin
            if (hit < 0 && held[i] == r.value) hit = i;
          end
          if (hit < 0) st = StNotFound;
        end
        ActDump: begin
          for (i = 0; i < held_cnt; i++) begin
            step_results.push_back(mk_result(StOk, held[i], i == held_cnt - 1));
          end
        end
        default: ;
      endcase
    end
    // Removing an entry closes the gap and keeps the order of the rest.
    if (hit >= 0) begin
      for (i = hit; i < held_cnt - 1; i++) held[i] = held[i+1];
      held_cnt--;
    end
    if (step_results.size() == 0) step_results.push_back(mk_result(st, '0, 1'b1));
  endfunction

  // Values lean toward a few small numbers so that repeats and delete hits
  // are common, with the extremes of the signed range thrown in.
  function automatic logic signed [DataW-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll < 2) return $signed($urandom_range(0, 8)) - 4;
    if (roll == 2) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(input logic [ActionW-1:0] act, input logic signed [DataW-1:0] val,
                         input bit typed, input logic [StatusW-1:0] st,
                         input logic [FillW-1:0] fl);
    dir_row_t row;
    row.req.action = act;
    row.req.value  = val;
    row.typed      = typed;
    row.status     = st;
    row.fill       = fl;
    directed_rows.push_back(row);
  endtask

  // Offers one request until it is accepted, then idles for a random gap.
  // Valid is only lowered when a gap follows, so back-to-back requests keep
  // it high without a second assignment in the same step.
  task automatic send_request(input req_t r, input bit typed,
                              input logic [StatusW-1:0] st, input logic [FillW-1:0] fl);
    int gap;
    in_req_i   <= r;
    drv_typed  <= typed;
    drv_status <= st;
    drv_fill   <= fl;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Scoreboard. Accepted results are checked against the oldest expectation
  // first; an accepted request then adds its own expectations. A request's
  // result can never leave in the cycle the request is taken.
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    res_t typed_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_res_o;
        if (expected_results.size() == 0) begin
          $display("%0t: expected no result, actual status %0d data %0d last %0d fill %0d",
                   $time, got.status, got.data, got.last, got.fill);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.data !== want.data) begin
            $display("%0t: data expected %0d, actual %0d", $time, want.data, got.data);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d, actual %0d", $time, want.last, got.last);
            errors++;
          end
          if (got.fill !== want.fill) begin
            $display("%0t: fill expected %0d, actual %0d", $time, want.fill, got.fill);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_request(in_req_i);
        if (drv_typed) begin
          typed_res.status = drv_status;
          typed_res.data   = '0;
          typed_res.last   = 1'b1;
          typed_res.fill   = drv_fill;
          expected_results.push_back(typed_res);
        end else begin
          foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
      end
    end
  end

  // Receiver. Each result gets a random stall before it is taken, except
  // when the sender asks for one long hold-off to back up the block.
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        n = HoldCycles;
      end else begin
        n = calm ? 0 : $urandom_range(0, 6);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int                      blk;
    int                      k;
    int                      roll;
    int                      push_cut;
    int                      pop_cut;
    bit                      grow;
    req_t                    r;

    // Directed table: empty-list cases, no-op actions, signed extremes,
    // a repeated value, front, middle and back deletes and several dumps.
    add_row(ActPopFront,  0,              1'b1, StEmpty,    5'd0);
    add_row(ActPopBack,   0,              1'b1, StEmpty,    5'd0);
    add_row(ActDelete,    0,              1'b1, StEmpty,    5'd0);
    add_row(ActDump,      0,              1'b1, StEmpty,    5'd0);
    add_row(ActUnused6,   32'sh5555_5555, 1'b1, StOk,       5'd0);
    add_row(ActUnused7,   -1,             1'b1, StOk,       5'd0);
    add_row(ActPushBack,  32'sh7fff_ffff, 1'b1, StOk,       5'd1);
    add_row(ActPushFront, 32'sh8000_0000, 1'b1, StOk,       5'd2);
    add_row(ActPushBack,  -1,             1'b1, StOk,       5'd3);
    add_row(ActPushBack,  0,              1'b1, StOk,       5'd4);
    add_row(ActPushBack,  5,              1'b1, StOk,       5'd5);
    add_row(ActPushFront, 5,              1'b1, StOk,       5'd6);
    add_row(ActDump,      0,              1'b0, StOk,       5'd0);
    add_row(ActDelete,    5,              1'b1, StOk,       5'd5);
    add_row(ActDelete,    12345,          1'b1, StNotFound, 5'd5);
    add_row(ActDelete,    -1,             1'b1, StOk,       5'd4);
    add_row(ActDump,      0,              1'b0, StOk,       5'd0);
    add_row(ActPopFront,  0,              1'b1, StOk,       5'd3);
    add_row(ActPopBack,   0,              1'b1, StOk,       5'd2);
    add_row(ActDump,      0,              1'b0, StOk,       5'd0);
    add_row(ActDelete,    0,              1'b1, StOk,       5'd1);
    add_row(ActPopBack,   0,              1'b1, StOk,       5'd0);
    add_row(ActDump,      0,              1'b1, StEmpty,    5'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].status, directed_rows[i].fill);
    end

    // Pressure phase: with the list drained, the receiver holds off for a
    // long stretch while pushes keep coming. The output register fills and
    // the block stalls its input; the last pushes meet a full list and the
    // dump that follows lists all sixteen entries.
    do @(posedge clk_i); while (expected_results.size() != 0);
    hold_pending = 1'b1;
    for (k = 0; k < BurstPushes; k++) begin
      r.action = k[0] ? ActPushFront : ActPushBack;
      r.value  = pick_value();
      send_request(r, 1'b0, StOk, '0);
    end
    r.action = ActDump;
    r.value  = $urandom;
    send_request(r, 1'b0, StOk, '0);

    // Random part in blocks that alternate between shrinking and growing the
    // list, so it swings between empty and full. Some blocks run with no
    // idling on either side.
    for (blk = 0; blk < RandBlocks; blk++) begin
      calm     = ($urandom_range(0, 3) == 0);
      grow     = blk[0];
      push_cut = grow ? 60 : 20;
      pop_cut  = push_cut + (grow ? 15 : 35);
      for (k = 0; k < BlockItems; k++) begin
        roll    = $urandom_range(0, 99);
        r.value = pick_value();
        if (roll < push_cut) begin
          r.action = roll[0] ? ActPushBack : ActPushFront;
        end else if (roll < pop_cut) begin
          r.action = roll[0] ? ActPopBack : ActPopFront;
        end else if (roll < pop_cut + 20) begin
          r.action = ActDelete;
          // Mostly delete something that is held, so hits land anywhere.
          if (held_cnt > 0 && $urandom_range(0, 2) != 0) begin
            r.value = held[$urandom_range(0, held_cnt - 1)];
          end
        end else if (roll < 95) begin
          r.action = ActDump;
        end else begin
          r.action = roll[0] ? ActUnused7 : ActUnused6;
        end
        send_request(r, 1'b0, StOk, '0);
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: expected %0d more results, actual none",
               $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("bounded_deque_with_delete_tb: done, clean");
    end else begin
      $display("bounded_deque_with_delete_tb: done, errors");
    end
    $finish;
  end

endmodule
